// ===== design/b32_pkg.sv =====
// b32_pkg: shared types, constants and the symbol alphabet for the base32 encoder.
// No dependencies; imported by the encoder top, b32_front, b32_queue and b32_back.
package b32_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
   localparam logic [4:0] SYM_MASK   = 5'h1F;
   localparam int unsigned PADDR_W   = 3;
   localparam logic [PADDR_W-1:0] CSR_PAD_ENABLE = 3'd0;

   // One accepted byte, classified: up to three alphabet indexes (two data
   // symbols and the flush symbol) and the number of '=' that follow.
   typedef struct packed {
      logic [2:0][4:0] syms;
      logic [1:0]      n_sym;   // 1 to 3
      logic [2:0]      n_pad;   // 0 to 7
      logic            last;
   } b32_desc_type;

   // RFC 4648 alphabet: A-Z then 2-7
   function automatic logic [7:0] b32_alpha(input logic [4:0] idx);
      logic [7:0] code;
      if (idx < 5'd26) begin
         code = 8'h41 + {3'b000, idx};
      end else begin
         code = 8'h32 + {3'b000, idx - 5'd26};
      end
      return code;
   endfunction

endpackage

// ===== design/b32_ifs.sv =====
// b32_ifs: valid/ready channel interfaces for input bytes and output symbols.
// No dependencies.
interface b32_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last_symbol;

   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== design/base32_stream_encoder.sv =====
// base32_stream_encoder: streaming RFC 4648 base32 encoder; one byte in, 1-8 chars out.
// A byte's first character passes the queue entry, then the output register, to rsp.
// Throughput: one character per cycle from the back end while rsp is ready; a last
// byte also emits its flush symbol, if any, and its '=' pads.
// Reset (sync, high): clears bit packer, queue, output stage; pad_enable returns to 1.
// Depends on b32_pkg, b32_ifs, b32_front, b32_queue, b32_back.
module base32_stream_encoder
   import b32_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   b32_req_if.sink            req_bus,
   b32_rsp_if.source          rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Config register: decoded on the word address, low byte bits ignored.
   logic pad_enable_ff, pad_enable_in;
   logic csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[PADDR_W-1:2] == CSR_PAD_ENABLE[PADDR_W-1:2]);
   assign prdata  = csr_hit ? {31'd0, pad_enable_ff} : 32'd0;

   always_comb begin
      pad_enable_in = pad_enable_ff;
      if (psel & penable & pwrite & pready & csr_hit) begin
         pad_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_enable_ff <= 1'b1;
      end else begin
         pad_enable_ff <= pad_enable_in;
      end
   end

   // Front: packs bits, classifies each byte into up to 3 symbols plus pad count.
   b32_desc_type front_desc, back_desc;
   logic         front_valid, front_ready;
   logic         back_valid, back_pop;

   b32_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_byte    (req_bus.data_byte),
      .in_last    (req_bus.last_byte),
      .pad_enable (pad_enable_ff),
      .in_ready   (req_bus.ready),
      .desc_valid (front_valid),
      .desc       (front_desc),
      .desc_ready (front_ready)
   );

   // Queue decouples byte intake from the back end, one char per cycle while rsp is ready.
   b32_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_desc  (front_desc),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_desc   (back_desc),
      .pop_ready  (back_pop)
   );

   // Back: walks each item's characters into the output register.
   b32_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (back_valid),
      .desc       (back_desc),
      .desc_pop   (back_pop),
      .out_valid  (rsp_bus.valid),
      .out_symbol (rsp_bus.symbol),
      .out_last   (rsp_bus.last_symbol),
      .out_ready  (rsp_bus.ready)
   );

endmodule

// ===== design/b32_front.sv =====
// b32_front: bit packer; splits each byte into symbol indexes plus pad count.
// Depends on b32_pkg.
module b32_front
   import b32_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [7:0]   in_byte,
   input  logic         in_last,
   input  logic         pad_enable,
   output logic         in_ready,
   output logic         desc_valid,
   output b32_desc_type desc,
   input  logic         desc_ready
);

   logic [3:0]  leftover_bits_ff, leftover_bits_in;
   logic [2:0]  leftover_count_ff, leftover_count_in;
   logic [2:0]  group_pos_ff, group_pos_in;

   logic [2:0]  cnt;
   logic [3:0]  total;
   logic [11:0] acc;
   logic        two;
   logic [3:0]  sh0, sh1, rem;
   logic [2:0]  rem3;
   logic [3:0]  rem_bits;
   logic        flush;
   logic [4:0]  s0, s1, fsym;
   logic [1:0]  n_sym;
   logic [2:0]  gp_new, pad_raw;
   logic [3:0]  pad_cap;
   logic [2:0]  pad_lim;
   logic        accept;

   assign in_ready   = desc_ready;
   assign desc_valid = in_valid;
   assign accept     = in_valid & desc_ready;

   always_comb begin
      cnt      = (leftover_count_ff > 3'd4) ? 3'd4 : leftover_count_ff;
      total    = {1'b0, cnt} + 4'd8;
      acc      = {leftover_bits_ff, in_byte};
      two      = (total >= 4'd10);
      sh0      = total - 4'd5;
      sh1      = total - 4'd10;
      s0       = 5'(acc >> sh0) & SYM_MASK;
      s1       = 5'(acc >> sh1) & SYM_MASK;
      rem      = two ? sh1 : sh0;
      rem3     = rem[2:0];
      rem_bits = acc[3:0] & 4'((5'd1 << rem3) - 5'd1);
      flush    = in_last & (rem3 != 3'd0);
      // leftover bits zero-filled on the right
      fsym     = ({1'b0, rem_bits} << (3'd5 - rem3)) & SYM_MASK;
      n_sym    = (two ? 2'd2 : 2'd1) + {1'b0, flush};
      gp_new   = group_pos_ff + {1'b0, n_sym};
      pad_raw  = 3'd0 - gp_new;
      pad_cap  = 4'd8 - {2'b00, n_sym};
      pad_lim  = ({1'b0, pad_raw} > pad_cap) ? pad_cap[2:0] : pad_raw;

      desc.syms[0] = s0;
      desc.syms[1] = two ? s1 : fsym;
      desc.syms[2] = fsym;
      desc.n_sym   = n_sym;
      desc.n_pad   = (in_last & pad_enable) ? pad_lim : 3'd0;
      desc.last    = in_last;

      leftover_bits_in  = leftover_bits_ff;
      leftover_count_in = leftover_count_ff;
      group_pos_in      = group_pos_ff;
      if (accept) begin
         if (in_last) begin
            leftover_bits_in  = 4'd0;
            leftover_count_in = 3'd0;
            group_pos_in      = 3'd0;
         end else begin
            leftover_bits_in  = rem_bits;
            leftover_count_in = rem3;
            group_pos_in      = gp_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= 4'd0;
         leftover_count_ff <= 3'd0;
         group_pos_ff      <= 3'd0;
      end else begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
         group_pos_ff      <= group_pos_in;
      end
   end

endmodule

// ===== design/b32_queue.sv =====
// b32_queue: small register FIFO of classified items between front and back.
// Depends on b32_pkg.
module b32_queue
   import b32_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  b32_desc_type push_desc,
   output logic         push_ready,
   output logic         pop_valid,
   output b32_desc_type pop_desc,
   input  logic         pop_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b32_desc_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== design/b32_back.sv =====
// b32_back: expands each classified item into characters, one per cycle while
// out_ready allows, into a registered output stage. Depends on b32_pkg.
module b32_back
   import b32_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         desc_valid,
   input  b32_desc_type desc,
   output logic         desc_pop,
   output logic         out_valid,
   output logic [7:0]   out_symbol,
   output logic         out_last,
   input  logic         out_ready
);

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] symbol_ff, symbol_in;
   logic       last_ff, last_in;
   logic [3:0] total;
   logic       at_end;
   logic       emit;

   assign out_valid  = valid_ff;
   assign out_symbol = symbol_ff;
   assign out_last   = last_ff;

   always_comb begin
      total    = {2'b00, desc.n_sym} + {1'b0, desc.n_pad};
      at_end   = (idx_ff == total - 4'd1);
      emit     = desc_valid & (~valid_ff | out_ready);
      desc_pop = emit & at_end;

      idx_in    = idx_ff;
      valid_in  = valid_ff & ~out_ready;
      symbol_in = symbol_ff;
      last_in   = last_ff;
      if (emit) begin
         valid_in  = 1'b1;
         symbol_in = (idx_ff < {2'b00, desc.n_sym}) ? b32_alpha(desc.syms[idx_ff[1:0]])
                                                    : PAD_CHAR;
         last_in   = desc.last & at_end;
         idx_in    = at_end ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
   end

endmodule
